[sv/nsrp_pkg.sv]
// ----------------------------------------------------------------------------
// nsrp_pkg: neighbour sample read planner definitions
// Default sizes, stream widths and configuration register indexes.
// ----------------------------------------------------------------------------
package nsrp_pkg;

    localparam int TABLE_DEPTH_DEF = 65536;
    localparam int MAX_FANOUT_DEF  = 64;
    localparam int BLOCK_WORDS_DEF = 128;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 1;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int SLOT_W  = 6;
    localparam int BLOCK_W = 25;
    localparam int WORD_W  = 7;
    localparam int RUN_W   = 6;
    localparam int FO_W    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_FANOUT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 8'd1;

    localparam logic [FO_W-1:0] FANOUT_RST = 7'd10;
    localparam logic [31:0]     PRNG_RST   = 32'd1;

endpackage

[sv/neighbor_sample_read_planner_core.sv]
// ----------------------------------------------------------------------------
// neighbor_sample_read_planner_core
// Loads a compressed-row offset table and plans 512-byte block reads for
// uniformly sampled neighbours of one node per sample transaction.
// ----------------------------------------------------------------------------
//  channel   | direction | transaction carries
//  s_axis    | in        | tuser: mode; tdata: table_index, table_value, node_id
//  m_axis    | out       | tuser: valid_res; tdata: slot .. run_in_block; tlast
//  cfg       | in        | index 0 fanout, index 1 prng_seed
//
//  A load transaction writes at most one table entry. A sample makes two reads
//  of the single offset table port (none when node_id+1 is off the table), then
//  issues one slot per cycle while m_axis is not stalled. Each result passes
//  through slot registers s1 to s5 and then the output register.
//  A stalled m_axis freezes the whole slot pipeline. No clearing pass: reset
//  only clears control state, fanout (10) and the generator state (1).
// ----------------------------------------------------------------------------
module neighbor_sample_read_planner_core #(
    parameter int TABLE_DEPTH = nsrp_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_FANOUT  = nsrp_pkg::MAX_FANOUT_DEF,
    parameter int BLOCK_WORDS = nsrp_pkg::BLOCK_WORDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // table_index[15:0], table_value[47:16], node_id[63:48]
    input  logic [nsrp_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // mode[0]
    input  logic [nsrp_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // slot[5:0], needs_read[6], block_number[31:7], word_in_block[38:32],
    // run_in_block[44:39], zero[47:45]
    output logic [nsrp_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // valid_res[0]
    output logic [nsrp_pkg::OUT_USER_W-1:0]  o_m_axis_tuser,
    output logic                             o_m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nsrp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nsrp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import nsrp_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = (AW > 16) ? AW : 16;
    localparam int RW = $clog2(BLOCK_WORDS) + 1;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BLOCK_WORDS);
    localparam logic [31:0] BW32  = 32'(BLOCK_WORDS);
    localparam logic [RW-1:0] BWR = RW'(BLOCK_WORDS);
    localparam logic [EW:0] DEPTH_X = (EW+1)'(TABLE_DEPTH);
    localparam logic [FO_W-1:0] FO_MAX = FO_W'(MAX_FANOUT);

    typedef enum logic [1:0] {S_IDLE, S_RD_LO, S_RD_HI, S_SLOTS} t_state;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              last;
        logic              vres;
        logic              first;
    } t_slot_ctl;

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    // ---------------------------------------------------------------- fields
    logic        w_mode;
    logic [15:0] w_tidx;
    logic [31:0] w_tval;
    logic [15:0] w_node;
    assign w_mode = i_s_axis_tuser[0];
    assign w_tidx = i_s_axis_tdata[15:0];
    assign w_tval = i_s_axis_tdata[47:16];
    assign w_node = i_s_axis_tdata[63:48];

    // ---------------------------------------------------------------- control
    t_state          r_state;
    logic [FO_W-1:0] r_fanout;
    logic [31:0]     r_prng;
    logic [FO_W-1:0] r_fo;
    logic [SLOT_W-1:0] r_j;
    logic [31:0]     r_base;
    logic [31:0]     r_degree;
    logic            r_rand;
    logic [AW-1:0]   r_addr_hi;
    logic [31:0]     r_rd_data;
    logic [31:0]     r_mem [TABLE_DEPTH];

    logic            w_adv;
    logic            w_in_acc;
    logic            w_cfg_acc;
    logic            w_issue;
    logic            w_last;
    logic            w_vres;
    logic [31:0]     w_rnd;
    logic [63:0]     w_prod;
    logic [31:0]     w_draw;
    logic [EW:0]     w_tidx_x;
    logic [EW:0]     w_node1_x;
    logic            w_tidx_ok;
    logic            w_node_ok;
    logic            w_mem_we;
    logic            w_mem_re;
    logic [AW-1:0]   w_raddr;
    logic [31:0]     w_diff;
    logic            w_mono;
    logic [FO_W-1:0] w_fo;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_acc = i_cfg_valid;

    assign w_tidx_x  = (EW+1)'(w_tidx);
    assign w_node1_x = (EW+1)'(w_node) + (EW+1)'(1);
    assign w_tidx_ok = w_tidx_x < DEPTH_X;
    assign w_node_ok = w_node1_x < DEPTH_X;

    assign w_mem_we = w_in_acc && !w_mode && w_tidx_ok;
    assign w_mem_re = (w_in_acc && w_mode && w_node_ok) || (r_state == S_RD_LO);
    assign w_raddr  = (r_state == S_RD_LO) ? r_addr_hi : AW'(w_node);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[AW'(w_tidx)] <= w_tval;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_comb begin
        if (r_fanout == '0) begin
            w_fo = FO_W'(1);
        end else if (r_fanout > FO_MAX) begin
            w_fo = FO_MAX;
        end else begin
            w_fo = r_fanout;
        end
    end

    assign w_diff  = r_rd_data - r_base;
    assign w_mono  = r_rd_data >= r_base;
    assign w_issue = (r_state == S_SLOTS) && w_adv;
    assign w_last  = (FO_W'(r_j) + FO_W'(1)) == r_fo;
    assign w_vres  = r_rand || (FO_W'(r_j) < r_degree[FO_W-1:0]);
    assign w_rnd   = xorshift(r_prng);
    assign w_prod  = {32'd0, w_rnd} * {32'd0, r_degree};
    assign w_draw  = r_rand ? w_prod[63:32] : 32'(r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fanout <= FANOUT_RST;
            r_prng   <= PRNG_RST;
            r_j      <= '0;
            r_rand   <= 1'b0;
        end else begin
            if (w_cfg_acc && i_cfg_index == CFG_FANOUT) begin
                r_fanout <= i_cfg_data[FO_W-1:0];
            end
            if (w_cfg_acc && i_cfg_index == CFG_SEED) begin
                r_prng <= (i_cfg_data == 32'd0) ? PRNG_RST : i_cfg_data;
            end else if (w_issue && r_rand) begin
                r_prng <= w_rnd;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && w_mode) begin
                        r_fo      <= w_fo;
                        r_j       <= '0;
                        r_addr_hi <= w_node1_x[AW-1:0];
                        if (w_node_ok) begin
                            r_state <= S_RD_LO;
                        end else begin
                            r_base   <= '0;
                            r_degree <= '0;
                            r_rand   <= 1'b0;
                            r_state  <= S_SLOTS;
                        end
                    end
                end
                S_RD_LO: begin
                    r_base  <= r_rd_data;
                    r_state <= S_RD_HI;
                end
                S_RD_HI: begin
                    r_degree <= w_mono ? w_diff : 32'd0;
                    r_rand   <= w_mono && (w_diff >= 32'(r_fo));
                    r_state  <= S_SLOTS;
                end
                S_SLOTS: begin
                    if (w_issue) begin
                        r_j <= r_j + SLOT_W'(1);
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- slot pipe
    logic            r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_o_valid;
    t_slot_ctl       r_s1_c, r_s2_c, r_s3_c, r_s4_c, r_s5_c;
    logic [31:0]     r_s1_draw;
    logic [31:0]     r_s1_base;
    logic [31:0]     r_s2_edge;
    logic [31:0]     r_s3_edge;
    logic [31:0]     r_s3_q;
    logic [31:0]     r_s4_q;
    logic [RW-1:0]   r_s4_rem;
    logic [31:0]     r_s5_q;
    logic [RW-1:0]   r_s5_rem;
    logic [31:0]     r_prev_blk;
    logic            r_have_prev;
    logic [RUN_W-1:0] r_run;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic            r_o_user;
    logic            r_o_last;

    logic [63:0]     w_qprod;
    logic            w_has_prev;
    logic            w_fresh;
    logic [RUN_W-1:0] n_run;

    assign w_adv      = !r_o_valid || i_m_axis_tready;
    assign w_qprod    = {32'd0, r_s2_edge} * {32'd0, RECIP};
    assign w_has_prev = r_have_prev && !r_s5_c.first;
    assign w_fresh    = !w_has_prev || (r_s5_q != r_prev_blk);
    assign n_run      = w_fresh ? '0 : r_run + RUN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_s5_v      <= 1'b0;
            r_o_valid   <= 1'b0;
            r_have_prev <= 1'b0;
            r_run       <= '0;
        end else if (w_adv) begin
            r_s1_v    <= w_issue;
            r_s1_c    <= '{slot: r_j, last: w_last, vres: w_vres, first: (r_j == '0)};
            r_s1_draw <= w_draw;
            r_s1_base <= r_base;

            r_s2_v    <= r_s1_v;
            r_s2_c    <= r_s1_c;
            r_s2_edge <= r_s1_base + r_s1_draw;

            r_s3_v    <= r_s2_v;
            r_s3_c    <= r_s2_c;
            r_s3_edge <= r_s2_edge;
            r_s3_q    <= w_qprod[63:32];

            r_s4_v    <= r_s3_v;
            r_s4_c    <= r_s3_c;
            r_s4_q    <= r_s3_q;
            r_s4_rem  <= r_s3_edge[RW-1:0] - RW'(r_s3_q * BW32);

            r_s5_v    <= r_s4_v;
            r_s5_c    <= r_s4_c;
            if (r_s4_rem >= BWR) begin
                r_s5_q   <= r_s4_q + 32'd1;
                r_s5_rem <= r_s4_rem - BWR;
            end else begin
                r_s5_q   <= r_s4_q;
                r_s5_rem <= r_s4_rem;
            end

            r_o_valid <= r_s5_v;
            r_o_user  <= r_s5_c.vres;
            r_o_last  <= r_s5_c.last;
            if (r_s5_c.vres) begin
                r_o_data <= {3'd0, n_run, WORD_W'(r_s5_rem), BLOCK_W'(r_s5_q),
                             w_fresh, r_s5_c.slot};
            end else begin
                r_o_data <= {(OUT_DATA_W-SLOT_W)'(0), r_s5_c.slot};
            end
            if (r_s5_v && r_s5_c.vres) begin
                r_have_prev <= 1'b1;
                r_prev_blk  <= r_s5_q;
                r_run       <= n_run;
            end else if (r_s5_v && r_s5_c.first) begin
                r_have_prev <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;
    assign o_m_axis_tlast  = r_o_last;

endmodule
